[design/wbf_pkg.sv]
`timescale 1ns / 1ps
package wbf_pkg;

    localparam int CoordW    = 32;
    localparam int FracB     = 16;
    localparam int OutW      = 32;
    localparam int CfgW      = 32;
    localparam int CfgIdxW   = 3;
    localparam int InDataW   = 6 * CoordW;
    localparam int OutDataW  = 4 * OutW;
    // reciprocal divider and log2 squaring chain share the same stages
    localparam int DivStages = FracB;
    localparam int DivBits   = 3;

    localparam logic [FracB-1:0] Ln2Q   = 16'hB172;
    localparam logic [OutW-1:0]  OutMax = 32'h7FFF_FFFF;
    localparam logic [OutW-1:0]  OutMin = 32'h8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INV_LENGTH   = 3'd0,
        CFG_FORCE_SCALE  = 3'd1,
        CFG_ENERGY_SCALE = 3'd2,
        CFG_COEF_ONE     = 3'd3,
        CFG_COEF_TWO     = 3'd4,
        CFG_COEF_THREE   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] inv_length_scale;
        logic [31:0] force_scale;
        logic [31:0] energy_scale;
        logic [31:0] coef_one;
        logic [31:0] coef_two;
        logic [31:0] coef_three;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
        logic [16:0]      b1;
        logic [15:0]      rsq;
        logic [4:0]       lexp;
        logic [31:0]      ynorm;
    } geo_t;

    typedef struct packed {
        logic [32:0]      inv;
        logic [21:0]      lg;
        logic [16:0]      b1;
        logic [15:0]      rsq;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } dl_t;

    typedef struct packed {
        logic             fbbig;
        logic [46:0]      fbm;
        logic             ppos;
        logic [36:0]      em;
        logic             eneg;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } pl_t;

endpackage

[design/wlc_bond_force_core.sv]
`timescale 1ns / 1ps
// worm-like-chain bond force engine: each input beat carries two atom positions (signed q16.16)
// and an energy request flag; each output beat carries the force on the first atom (negate it
// for the second), the bond energy (zero unless requested) and an overstretch flag. the core
// takes one beat per clock and returns one result per input through 5 geometry stages,
// 16 stages in which a restoring divider (3 quotient bits per stage) forms 2^32/b1 while a
// squaring chain forms log2(b1) one fraction bit per stage, 4 polynomial stages and 2 output
// scaling stages. the whole pipe advances together; it holds when the output beat is not
// taken, so s_tready follows m_tready whenever a result is waiting. the six scale and
// coefficient registers are written through the cfg port at any time, take effect at once and
// must only change while no bond is in flight.
module wlc_bond_force_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // bond input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [wbf_pkg::InDataW-1:0]    s_tdata,
    // want_energy
    input  logic [0:0]                     s_tuser,
    // force output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // force_x, force_y, force_z, energy
    output logic [wbf_pkg::OutDataW-1:0]   m_tdata,
    // overstretched
    output logic [0:0]                     m_tuser,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wbf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [wbf_pkg::CfgW-1:0]       cfg_data
);
    import wbf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic en;

    logic geo_valid;
    geo_t geo;
    logic dl_valid;
    dl_t  dl;
    logic pl_valid;
    pl_t  pl;
    logic res_over;

    // register file, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_INV_LENGTH:   cfg_next.inv_length_scale = cfg_data;
                CFG_FORCE_SCALE:  cfg_next.force_scale      = cfg_data;
                CFG_ENERGY_SCALE: cfg_next.energy_scale     = cfg_data;
                CFG_COEF_ONE:     cfg_next.coef_one         = cfg_data;
                CFG_COEF_TWO:     cfg_next.coef_two         = cfg_data;
                CFG_COEF_THREE:   cfg_next.coef_three       = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_length_scale <= 32'h0001_0000;
            cfg_reg.force_scale      <= 32'h0001_0000;
            cfg_reg.energy_scale     <= 32'h0000_8000;
            cfg_reg.coef_one         <= '0;
            cfg_reg.coef_two         <= '0;
            cfg_reg.coef_three       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // the pipe moves whenever the output slot is free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    wbf_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_data   (s_tdata),
        .in_want   (s_tuser[0]),
        .cfg       (cfg_reg),
        .out_valid (geo_valid),
        .out_geo   (geo)
    );

    // reciprocal of b1 and log2(b1) in lockstep
    wbf_divlog u_divlog (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_valid),
        .in_geo    (geo),
        .out_valid (dl_valid),
        .out_dl    (dl)
    );

    wbf_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dl_valid),
        .in_dl     (dl),
        .cfg       (cfg_reg),
        .out_valid (pl_valid),
        .out_pl    (pl)
    );

    // final stage doubles as the output register
    wbf_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_valid),
        .in_pl     (pl),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_over  (res_over)
    );

    assign m_tuser[0] = res_over;

`ifndef SYNTH
    // overstretched bonds only ever report a zero or full-scale force_x
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[31:0] == '0 || m_tdata[31:0] == OutMin || m_tdata[31:0] == OutMax))
        else $error("overstretched force not saturated");

    // overstretched energy is either dropped or pinned to the most negative value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[127:96] == '0 || m_tdata[127:96] == OutMin))
        else $error("overstretched energy not saturated");

    // no result can come out right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

[design/wbf_geom.sv]
`timescale 1ns / 1ps
module wbf_geom (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [wbf_pkg::InDataW-1:0]  in_data,
    input  logic                         in_want,
    input  wbf_pkg::cfg_t                cfg,
    output logic                         out_valid,
    output wbf_pkg::geo_t                out_geo
);
    import wbf_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             want;
    } g1_t;

    typedef struct packed {
        logic [2:0][15:0] ul;
        logic             over;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             want;
    } g2_t;

    typedef struct packed {
        logic [2:0][31:0] sq;
        logic             over;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             want;
    } g3_t;

    typedef struct packed {
        logic [16:0]      b1;
        logic [15:0]      rsq;
        logic             over;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             want;
    } g4_t;

    g1_t  s1_reg, s1_next;
    g2_t  s2_reg, s2_next;
    g3_t  s3_reg, s3_next;
    g4_t  s4_reg, s4_next;
    geo_t s5_reg, s5_next;
    logic [4:0] vld_reg, vld_next;

    always_comb begin
        logic [32:0] diff;
        logic [32:0] negd;
        logic [63:0] prod;
        logic [33:0] rsum;
        logic        ov;

        // stage 1: component differences as sign and magnitude
        s1_next.want = in_want;
        for (int i = 0; i < 3; i++) begin
            diff = {in_data[CoordW*i+CoordW-1], in_data[CoordW*i +: CoordW]}
                 - {in_data[CoordW*(i+3)+CoordW-1], in_data[CoordW*(i+3) +: CoordW]};
            negd = ~diff + 33'd1;
            s1_next.dn[i] = diff[32];
            s1_next.dm[i] = diff[32] ? negd[31:0] : diff[31:0];
        end

        // stage 2: scale by 1/q0
        s2_next.dm   = s1_reg.dm;
        s2_next.dn   = s1_reg.dn;
        s2_next.want = s1_reg.want;
        s2_next.over = 1'b0;
        for (int i = 0; i < 3; i++) begin
            prod = {32'b0, s1_reg.dm[i]} * {32'b0, cfg.inv_length_scale};
            s2_next.ul[i] = prod[31:16];
            if (|prod[63:32]) s2_next.over = 1'b1;
        end

        // stage 3: squares
        s3_next.dm   = s2_reg.dm;
        s3_next.dn   = s2_reg.dn;
        s3_next.want = s2_reg.want;
        s3_next.over = s2_reg.over;
        for (int i = 0; i < 3; i++) begin
            s3_next.sq[i] = {16'b0, s2_reg.ul[i]} * {16'b0, s2_reg.ul[i]};
        end

        // stage 4: rsq and b1, forced to a harmless length when overstretched
        rsum = {2'b0, s3_reg.sq[0]} + {2'b0, s3_reg.sq[1]} + {2'b0, s3_reg.sq[2]};
        ov   = s3_reg.over | (|rsum[33:32]);
        s4_next.dm   = s3_reg.dm;
        s4_next.dn   = s3_reg.dn;
        s4_next.want = s3_reg.want;
        s4_next.over = ov;
        s4_next.rsq  = ov ? 16'h0 : rsum[31:16];
        s4_next.b1   = ov ? 17'h1_0000 : (17'h1_0000 - {1'b0, rsum[31:16]});

        // stage 5: normalize b1 for the log2 chain
        s5_next.dm   = s4_reg.dm;
        s5_next.dn   = s4_reg.dn;
        s5_next.want = s4_reg.want;
        s5_next.over = s4_reg.over;
        s5_next.rsq  = s4_reg.rsq;
        s5_next.b1   = s4_reg.b1;
        s5_next.lexp = 5'd0;
        for (int k = 0; k < 17; k++) begin
            if (s4_reg.b1[k]) s5_next.lexp = 5'(k);
        end
        s5_next.ynorm = {15'b0, s4_reg.b1} << (5'd31 - s5_next.lexp);
    end

    assign vld_next = {vld_reg[3:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_geo   = s5_reg;

endmodule

[design/wbf_divlog.sv]
`timescale 1ns / 1ps
module wbf_divlog (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  wbf_pkg::geo_t in_geo,
    output logic          out_valid,
    output wbf_pkg::dl_t  out_dl
);
    import wbf_pkg::*;

    typedef struct packed {
        logic [16:0]      rem;
        logic [32:0]      quo;
        logic [31:0]      ly;
        logic [15:0]      lfrac;
        logic [4:0]       lexp;
        logic [16:0]      b1;
        logic [15:0]      rsq;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } dls_t;

    dls_t st_reg  [DivStages];
    dls_t st_next [DivStages];
    logic [DivStages-1:0] vld_reg, vld_next;

    always_comb begin
        dls_t        cur;
        logic [17:0] trial;
        logic [63:0] yy;
        for (int k = 0; k < DivStages; k++) begin
            if (k == 0) begin
                cur.rem   = '0;
                cur.quo   = '0;
                cur.ly    = in_geo.ynorm;
                cur.lfrac = '0;
                cur.lexp  = in_geo.lexp;
                cur.b1    = in_geo.b1;
                cur.rsq   = in_geo.rsq;
                cur.dm    = in_geo.dm;
                cur.dn    = in_geo.dn;
                cur.over  = in_geo.over;
                cur.want  = in_geo.want;
            end else begin
                cur = st_reg[k-1];
            end
            // restoring division of 2^32 by b1, DivBits (3) quotient bits per stage
            for (int s = 0; s < DivBits; s++) begin
                trial = {cur.rem, ((DivBits * DivStages - 1 - DivBits * k - s) == 2 * FracB)};
                if (trial >= {1'b0, cur.b1}) begin
                    trial   = trial - {1'b0, cur.b1};
                    cur.rem = trial[16:0];
                    cur.quo = {cur.quo[31:0], 1'b1};
                end else begin
                    cur.rem = trial[16:0];
                    cur.quo = {cur.quo[31:0], 1'b0};
                end
            end
            // one squaring step of the log2 fraction
            yy = {32'b0, cur.ly} * {32'b0, cur.ly};
            if (yy[63]) begin
                cur.ly    = yy[63:32];
                cur.lfrac = {cur.lfrac[14:0], 1'b1};
            end else begin
                cur.ly    = yy[62:31];
                cur.lfrac = {cur.lfrac[14:0], 1'b0};
            end
            st_next[k] = cur;
        end
    end

    assign vld_next = {vld_reg[DivStages-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DivStages; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid   = vld_reg[DivStages-1];
    assign out_dl.inv  = st_reg[DivStages-1].quo;
    assign out_dl.lg   = {6'({1'b0, st_reg[DivStages-1].lexp} - 6'd16),
                          st_reg[DivStages-1].lfrac};
    assign out_dl.b1   = st_reg[DivStages-1].b1;
    assign out_dl.rsq  = st_reg[DivStages-1].rsq;
    assign out_dl.dm   = st_reg[DivStages-1].dm;
    assign out_dl.dn   = st_reg[DivStages-1].dn;
    assign out_dl.over = st_reg[DivStages-1].over;
    assign out_dl.want = st_reg[DivStages-1].want;

endmodule

[design/wbf_poly.sv]
`timescale 1ns / 1ps
module wbf_poly (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  wbf_pkg::dl_t  in_dl,
    input  wbf_pkg::cfg_t cfg,
    output logic          out_valid,
    output wbf_pkg::pl_t  out_pl
);
    import wbf_pkg::*;

    typedef struct packed {
        logic [47:0]      inv2q;
        logic [47:0]      c1inv;
        logic [31:0]      c3b1;
        logic [20:0]      lnbm;
        logic             lnbneg;
        logic [31:0]      c2rs;
        logic [31:0]      c3rs;
        logic [16:0]      half;
        logic [32:0]      inv;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } pb1_t;

    typedef struct packed {
        logic [50:0]      p;
        logic [35:0]      c1lnb;
        logic             c1lnbneg;
        logic [31:0]      c2rs;
        logic [31:0]      th;
        logic [32:0]      inv;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } pb2_t;

    typedef struct packed {
        logic [56:0]      flo;
        logic [56:0]      fhi;
        logic             ppos;
        logic [37:0]      e;
        logic [2:0][31:0] dm;
        logic [2:0]       dn;
        logic             over;
        logic             want;
    } pb3_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [50:0] neg51(input logic [50:0] v, input logic n);
        neg51 = n ? (~v + 51'd1) : v;
    endfunction

    function automatic logic [37:0] neg38(input logic [37:0] v, input logic n);
        neg38 = n ? (~v + 38'd1) : v;
    endfunction

    pb1_t b1_reg, b1_next;
    pb2_t b2_reg, b2_next;
    pb3_t b3_reg, b3_next;
    pl_t  b4_reg, b4_next;
    logic [3:0] vld_reg, vld_next;

    always_comb begin
        logic [31:0] c1m, c2m, c3m;
        logic [21:0] lgn;
        logic [20:0] lgm;
        logic [63:0] m64;
        logic [64:0] m65;
        logic [48:0] m49;
        logic [36:0] m37;
        logic [47:0] m48;
        logic [17:0] s18;
        logic [52:0] m53;
        logic [49:0] pm;
        logic [50:0] pn;
        logic [81:0] fbprod;
        logic [37:0] en38;

        c1m = mag32(cfg.coef_one);
        c2m = mag32(cfg.coef_two);
        c3m = mag32(cfg.coef_three);

        // stage 1: independent products
        m64 = {32'b0, in_dl.inv[31:0]} * {32'b0, in_dl.inv[31:0]};
        b1_next.inv2q = in_dl.inv[32] ? 48'hFFFF_FFFF_FFFF : m64[63:16];
        m65 = {33'b0, c1m} * {32'b0, in_dl.inv};
        b1_next.c1inv = m65[63:16];
        m49 = {17'b0, c3m} * {32'b0, in_dl.b1};
        b1_next.c3b1 = m49[47:16];
        lgn = ~in_dl.lg + 22'd1;
        lgm = in_dl.lg[21] ? lgn[20:0] : in_dl.lg[20:0];
        m37 = {16'b0, lgm} * {21'b0, Ln2Q};
        b1_next.lnbm   = m37[36:16];
        b1_next.lnbneg = in_dl.lg[21];
        m48 = {16'b0, c2m} * {32'b0, in_dl.rsq};
        b1_next.c2rs = m48[47:16];
        m48 = {16'b0, c3m} * {32'b0, in_dl.rsq};
        b1_next.c3rs = m48[47:16];
        s18 = 18'h1_0000 + {1'b0, in_dl.b1};
        b1_next.half = s18[17:1];
        b1_next.inv  = in_dl.inv;
        b1_next.dm   = in_dl.dm;
        b1_next.dn   = in_dl.dn;
        b1_next.over = in_dl.over;
        b1_next.want = in_dl.want;

        // stage 2: force polynomial, energy products
        b2_next.p = {3'b0, b1_reg.inv2q}
                  + neg51({3'b0, b1_reg.c1inv}, ~cfg.coef_one[31])
                  + {{19{cfg.coef_two[31]}}, cfg.coef_two}
                  + neg51({19'b0, b1_reg.c3b1}, cfg.coef_three[31]);
        m53 = {21'b0, c1m} * {32'b0, b1_reg.lnbm};
        b2_next.c1lnb    = m53[51:16];
        b2_next.c1lnbneg = cfg.coef_one[31] ^ b1_reg.lnbneg;
        b2_next.c2rs     = b1_reg.c2rs;
        m49 = {17'b0, b1_reg.c3rs} * {32'b0, b1_reg.half};
        b2_next.th   = m49[47:16];
        b2_next.inv  = b1_reg.inv;
        b2_next.dm   = b1_reg.dm;
        b2_next.dn   = b1_reg.dn;
        b2_next.over = b1_reg.over;
        b2_next.want = b1_reg.want;

        // stage 3: force scale partial products, energy sum
        pn = ~b2_reg.p + 51'd1;
        pm = b2_reg.p[50] ? pn[49:0] : b2_reg.p[49:0];
        b3_next.flo  = {25'b0, cfg.force_scale} * {32'b0, pm[24:0]};
        b3_next.fhi  = {25'b0, cfg.force_scale} * {32'b0, pm[49:25]};
        b3_next.ppos = ~b2_reg.p[50] && (b2_reg.p != 51'd0);
        b3_next.e    = neg38({5'b0, b2_reg.inv}, 1'b1)
                     + neg38({2'b0, b2_reg.c1lnb}, ~b2_reg.c1lnbneg)
                     + neg38({6'b0, b2_reg.c2rs}, ~cfg.coef_two[31])
                     + neg38({6'b0, b2_reg.th}, cfg.coef_three[31]);
        b3_next.dm   = b2_reg.dm;
        b3_next.dn   = b2_reg.dn;
        b3_next.over = b2_reg.over;
        b3_next.want = b2_reg.want;

        // stage 4: fbond magnitude, clipped where it saturates any force anyway
        fbprod = {b3_reg.fhi, 25'b0} + {25'b0, b3_reg.flo};
        b4_next.fbbig = |fbprod[81:63];
        b4_next.fbm   = fbprod[62:16];
        b4_next.ppos  = b3_reg.ppos;
        en38 = ~b3_reg.e + 38'd1;
        b4_next.em    = b3_reg.e[37] ? en38[36:0] : b3_reg.e[36:0];
        b4_next.eneg  = b3_reg.e[37];
        b4_next.dm    = b3_reg.dm;
        b4_next.dn    = b3_reg.dn;
        b4_next.over  = b3_reg.over;
        b4_next.want  = b3_reg.want;
    end

    assign vld_next = {vld_reg[2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            b4_reg <= b4_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_pl    = b4_reg;

endmodule

[design/wbf_scale.sv]
`timescale 1ns / 1ps
module wbf_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  wbf_pkg::pl_t                  in_pl,
    input  wbf_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    output logic [wbf_pkg::OutDataW-1:0]  out_data,
    output logic                          out_over
);
    import wbf_pkg::*;

    typedef struct packed {
        logic [2:0][47:0] plo;
        logic [2:0][62:0] phi;
        logic [2:0]       fsat;
        logic [2:0]       dmnz;
        logic [2:0]       dn;
        logic             ppos;
        logic [47:0]      elo;
        logic [52:0]      ehi;
        logic             eneg;
        logic             over;
        logic             want;
    } sc1_t;

    typedef struct packed {
        logic [OutDataW-1:0] data;
        logic                over;
    } sc2_t;

    sc1_t s1_reg, s1_next;
    sc2_t s2_reg, s2_next;
    logic [1:0] vld_reg, vld_next;

    always_comb begin
        logic [63:0]   fmag;
        logic [53:0]   emag;
        logic          neg;
        logic          sat;
        logic [OutW-1:0] val;

        // stage 1: per-lane partial products
        for (int i = 0; i < 3; i++) begin
            s1_next.plo[i]  = {16'b0, in_pl.dm[i]} * {32'b0, in_pl.fbm[15:0]};
            s1_next.phi[i]  = {31'b0, in_pl.dm[i]} * {32'b0, in_pl.fbm[46:16]};
            s1_next.dmnz[i] = in_pl.dm[i] != 32'd0;
            s1_next.fsat[i] = in_pl.fbbig && (in_pl.dm[i] != 32'd0);
        end
        s1_next.dn   = in_pl.dn;
        s1_next.ppos = in_pl.ppos;
        s1_next.elo  = {16'b0, cfg.energy_scale} * {32'b0, in_pl.em[15:0]};
        s1_next.ehi  = {21'b0, cfg.energy_scale} * {32'b0, in_pl.em[36:16]};
        s1_next.eneg = in_pl.eneg;
        s1_next.over = in_pl.over;
        s1_next.want = in_pl.want;

        // stage 2: sum, saturate, sign, overstretch override
        for (int i = 0; i < 3; i++) begin
            fmag = {1'b0, s1_reg.phi[i]} + {32'b0, s1_reg.plo[i][47:16]};
            sat  = s1_reg.fsat[i] || (|fmag[63:31]);
            neg  = s1_reg.dn[i] ^ s1_reg.ppos;
            if (s1_reg.over) begin
                if ((cfg.force_scale != 32'd0) && s1_reg.dmnz[i]) begin
                    val = s1_reg.dn[i] ? OutMax : OutMin;
                end else begin
                    val = '0;
                end
            end else if (sat) begin
                val = neg ? OutMin : OutMax;
            end else begin
                val = neg ? (~fmag[31:0] + 32'd1) : fmag[31:0];
            end
            s2_next.data[OutW*i +: OutW] = val;
        end
        emag = {1'b0, s1_reg.ehi} + {22'b0, s1_reg.elo[47:16]};
        sat  = |emag[53:31];
        if (!s1_reg.want) begin
            val = '0;
        end else if (s1_reg.over) begin
            val = (cfg.energy_scale != 32'd0) ? OutMin : '0;
        end else if (sat) begin
            val = s1_reg.eneg ? OutMin : OutMax;
        end else begin
            val = s1_reg.eneg ? (~emag[31:0] + 32'd1) : emag[31:0];
        end
        s2_next.data[OutW*3 +: OutW] = val;
        s2_next.over = s1_reg.over;
    end

    assign vld_next = {vld_reg[0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_data  = s2_reg.data;
    assign out_over  = s2_reg.over;

endmodule
